/* rtl/mcid_pkg.sv */
package mcid_pkg;

  localparam int PinCount   = 16;
  localparam int ThrW       = 16;
  localparam int ThrPerReg  = 4;
  localparam int NumCfg     = 4;
  localparam int CfgIdxW    = 2;
  localparam int CfgW       = ThrW * ThrPerReg;
  localparam int StableW    = 17;
  localparam int TsW        = 32;

  localparam logic [StableW-1:0] StableMax   = {StableW{1'b1}};
  localparam logic [CfgW-1:0]    ThreshReset = 64'h0014_0014_0014_0014;

  typedef struct packed {
    logic [PinCount-1:0] hit;
    logic [PinCount-1:0] level;
  } lane_res_t;

endpackage

/* rtl/mcid_lane.sv */
module mcid_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  logic                              level,
  input  logic                              prev,
  input  logic [mcid_pkg::TsW-1:0]          elapsed,
  input  logic [mcid_pkg::ThrW-1:0]         thr,
  output logic                              hit
);

  logic [mcid_pkg::StableW-1:0] stable_r;
  logic [mcid_pkg::StableW-1:0] stable_nxt;
  logic [mcid_pkg::StableW-1:0] stable_upd;
  logic [mcid_pkg::TsW:0]       sum;
  logic                         same;
  logic                         sat;

  always_comb begin
    same       = (level == prev);
    sum        = {{(mcid_pkg::TsW + 1 - mcid_pkg::StableW){1'b0}}, stable_r}
               + {1'b0, elapsed};
    sat        = |sum[mcid_pkg::TsW:mcid_pkg::StableW];
    stable_upd = sat ? mcid_pkg::StableMax : sum[mcid_pkg::StableW-1:0];
    stable_nxt = same ? stable_upd : '0;
    hit        = same && (stable_upd >
                 {{(mcid_pkg::StableW - mcid_pkg::ThrW){1'b0}}, thr});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
    end else if (fire) begin
      stable_r <= stable_nxt;
    end
  end

endmodule

/* rtl/mcid_merge.sv */
module mcid_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  mcid_pkg::lane_res_t               res,
  output logic [mcid_pkg::PinCount-1:0]     word_nxt
);

  logic [mcid_pkg::PinCount-1:0] word_r;

  always_comb begin
    word_nxt = (res.hit & res.level) | (~res.hit & word_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else if (fire) begin
      word_r <= word_nxt;
    end
  end

endmodule

/* rtl/multi_channel_input_debouncer.sv */
// Sixteen-pin time-based debouncer. Each item carries a raw pin sample and
// a millisecond timestamp; every pin has its own lane that accumulates how
// long its level has held (saturating at 131071 ms) and copies the raw level
// to the debounced bit once that time exceeds the pin's 16-bit threshold.
// Thresholds sit four to a 64-bit register (pin 4*k+j in bits 16*j+15..16*j
// of register k) and reset to 20 ms each. The block takes one item per clock
// while in_stall is low and returns one registered debounced word per item;
// all lanes update in the accepting cycle; a two-entry output buffer lets one
// more item in while output stalls. Write thresholds only while idle.
module multi_channel_input_debouncer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mcid_pkg::PinCount-1:0]       in_raw_levels,
  input  logic [mcid_pkg::TsW-1:0]            in_now_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mcid_pkg::PinCount-1:0]       out_debounced_levels,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mcid_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [mcid_pkg::CfgW-1:0]           cfg_data
);

  logic [mcid_pkg::CfgW-1:0]     thr_r [mcid_pkg::NumCfg];
  logic [mcid_pkg::PinCount-1:0] prev_raw_r;
  logic [mcid_pkg::TsW-1:0]      last_ts_r;
  logic                          first_r;
  logic [mcid_pkg::TsW-1:0]      elapsed;
  logic                          in_fire;
  logic                          out_fire;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [mcid_pkg::PinCount-1:0] out_data_r;
  logic [mcid_pkg::PinCount-1:0] out_data_nxt;
  logic                          skid_valid_r;
  logic                          skid_valid_nxt;
  logic [mcid_pkg::PinCount-1:0] skid_data_r;
  logic [mcid_pkg::PinCount-1:0] skid_data_nxt;
  logic [mcid_pkg::PinCount-1:0] word_nxt;
  logic [mcid_pkg::PinCount-1:0] lane_hit;
  mcid_pkg::lane_res_t           res;

  assign cfg_ready            = 1'b1;
  assign in_stall             = skid_valid_r;
  assign in_fire              = in_valid && !in_stall;
  assign out_valid            = out_valid_r;
  assign out_debounced_levels = out_data_r;
  assign out_fire             = out_valid_r && !out_stall;
  assign elapsed              = first_r ? '0 : (in_now_ms - last_ts_r);
  assign res                  = {lane_hit, in_raw_levels};

  for (genvar i = 0; i < mcid_pkg::PinCount; i++) begin : g_lane
    localparam int Reg = i / mcid_pkg::ThrPerReg;
    localparam int Sub = i % mcid_pkg::ThrPerReg;
    mcid_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .fire    (in_fire),
      .level   (in_raw_levels[i]),
      .prev    (prev_raw_r[i]),
      .elapsed (elapsed),
      .thr     (thr_r[Reg][Sub*mcid_pkg::ThrW +: mcid_pkg::ThrW]),
      .hit     (lane_hit[i])
    );
  end

  mcid_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .res      (res),
    .word_nxt (word_nxt)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = in_fire;
        out_data_nxt   = word_nxt;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r <= '1;
      last_ts_r  <= '0;
      first_r    <= 1'b1;
    end else if (in_fire) begin
      prev_raw_r <= in_raw_levels;
      last_ts_r  <= in_now_ms;
      first_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mcid_pkg::NumCfg; k++) begin
        thr_r[k] <= mcid_pkg::ThreshReset;
      end
    end else if (cfg_valid && cfg_ready) begin
      thr_r[cfg_index] <= cfg_data;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_item_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item left no result");

  a_first_cleared_by_item: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(first_r) |-> $past(in_fire))
    else $error("first-sample flag dropped without an item");

endmodule
